[rtl/assert_macros.svh]
// assertion helpers used by line_sensor_centroid.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define LSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define LSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LSC_ASSERT_NOW(label, ante, cons, msg)

`define LSC_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

[rtl/lsc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lsc_pkg;

    localparam int SENSOR_COUNT = 8;
    localparam int NSENS = (SENSOR_COUNT < 4) ? 4 : ((SENSOR_COUNT > 8) ? 8 : SENSOR_COUNT);
    localparam int MAX_SENS = 8;
    localparam int SAMPLE_W = 12;
    localparam int ERR_W = 10;
    localparam int WEIGHT_STEP = 50;

    function automatic int weight_of(input int idx);
        return (idx * 2 - (NSENS - 1)) * WEIGHT_STEP;
    endfunction

    function automatic int max_abs_sum();
        int acc;
        acc = 0;
        for (int i = 0; i < NSENS; i++)
        begin
            if (weight_of(i) > 0)
            begin
                acc += weight_of(i);
            end
        end
        return acc;
    endfunction

    localparam int MAG_W = $clog2(max_abs_sum() + 1);
    localparam int SUM_W = MAG_W + 1;
    localparam int CNT_W = $clog2(NSENS + 1);

    function automatic logic signed [SUM_W-1:0] lane_weight(input int idx);
        return SUM_W'(weight_of(idx));
    endfunction

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_0;
        logic [SAMPLE_W-1:0] sample_1;
        logic [SAMPLE_W-1:0] sample_2;
        logic [SAMPLE_W-1:0] sample_3;
        logic [SAMPLE_W-1:0] sample_4;
        logic [SAMPLE_W-1:0] sample_5;
        logic [SAMPLE_W-1:0] sample_6;
        logic [SAMPLE_W-1:0] sample_7;
    } in_t;

    typedef struct packed {
        logic signed [ERR_W-1:0] line_error;
        logic [MAX_SENS-1:0]     black_mask;
        logic                    all_black;
        logic                    all_white;
        logic                    approach_marker;
        logic                    error_held;
    } out_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [CNT_W-1:0]        black_count;
        logic [MAX_SENS-1:0]     mask;
        logic                    all_black;
        logic                    all_white;
        logic                    approach;
    } merge_t;

endpackage

`default_nettype wire

[rtl/line_sensor_centroid.sv]
// Line sensor centroid. Takes one scan of eight 12-bit reflectance samples per
// transfer and returns one result: the weighted centroid of the sensors at or
// above black_threshold (weights (2i-7)*50, truncated toward zero), the black
// mask and the all-black, all-white and approach-marker flags. With no black
// sensor the last non-zero error is repeated and error_held is set. The parallel
// lanes compare all sensors as the scan is taken. After the input transfer the
// lanes are merged, the radix-2 divider divides by the black count (ten quotient
// bits, then its done flag) and the result is loaded into the output register.
// The next scan is taken the cycle after the result is loaded, even while that
// result still waits on out_ready, so no new scan is taken while one is in
// progress; a stalled output delays the load and so the next scan.
// black_threshold resets to 2048 and is written through cfg_wr_en/cfg_wr_data.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module line_sensor_centroid
    import lsc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire in_t                 in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output out_t                     out_data,
    input  wire logic                cfg_wr_en,
    input  wire logic [SAMPLE_W-1:0] cfg_wr_data
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MERGE = 4'b0010,
        S_DIV   = 4'b0100,
        S_OUT   = 4'b1000
    } state_t;

    state_t                  state_reg, state_next;
    logic [SAMPLE_W-1:0]     thr_reg;
    logic signed [ERR_W-1:0] held_reg, held_next;
    logic [NSENS-1:0]        black_reg;
    logic signed [SUM_W-1:0] contrib_reg [NSENS];
    out_t                    out_data_reg, out_data_next;
    logic                    out_valid_reg, out_valid_next;

    logic [SAMPLE_W-1:0]     samples [MAX_SENS];
    logic [NSENS-1:0]        lane_black;
    logic signed [SUM_W-1:0] lane_contrib [NSENS];
    merge_t                  merged;
    logic                    in_xfer;
    logic                    out_load;
    logic                    div_start;
    logic                    div_busy;
    logic                    div_done;
    logic [MAG_W-1:0]        div_quo;
    logic [SUM_W-1:0]        sum_mag;
    logic signed [ERR_W-1:0] quo_err;
    logic signed [ERR_W-1:0] err_val;

    assign samples[0] = in_data.sample_0;
    assign samples[1] = in_data.sample_1;
    assign samples[2] = in_data.sample_2;
    assign samples[3] = in_data.sample_3;
    assign samples[4] = in_data.sample_4;
    assign samples[5] = in_data.sample_5;
    assign samples[6] = in_data.sample_6;
    assign samples[7] = in_data.sample_7;

    for (genvar g = 0; g < NSENS; g++)
    begin : g_lane
        lsc_lane u_lane (
            .sample    (samples[g]),
            .threshold (thr_reg),
            .weight    (lane_weight(g)),
            .black     (lane_black[g]),
            .contrib   (lane_contrib[g])
        );
    end

    lsc_merge u_merge (
        .black   (black_reg),
        .contrib (contrib_reg),
        .merged  (merged)
    );

    assign sum_mag   = merged.sum[SUM_W-1] ? SUM_W'(-merged.sum) : merged.sum;
    assign div_start = (state_reg == S_MERGE);

    lsc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_mag[MAG_W-1:0]),
        .divisor  (merged.black_count),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid & in_ready;
    assign out_load = (state_reg == S_OUT) & (~out_valid_reg | out_ready);

    always_comb
    begin
        quo_err = ERR_W'(div_quo);
        if (merged.sum[SUM_W-1])
        begin
            quo_err = -quo_err;
        end
        err_val = merged.all_white ? held_reg : quo_err;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = S_MERGE;
                end
            end
            S_MERGE:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        held_next      = held_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        if (out_load)
        begin
            out_valid_next                = 1'b1;
            out_data_next.line_error      = err_val;
            out_data_next.black_mask      = merged.mask;
            out_data_next.all_black       = merged.all_black;
            out_data_next.all_white       = merged.all_white;
            out_data_next.approach_marker = merged.approach;
            out_data_next.error_held      = merged.all_white;
            // a zero centroid leaves the held error alone
            if (!merged.all_white && (quo_err != '0))
            begin
                held_next = quo_err;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            thr_reg       <= SAMPLE_W'(2048);
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (in_xfer)
        begin
            black_reg <= lane_black;
            for (int i = 0; i < NSENS; i++)
            begin
                contrib_reg[i] <= lane_contrib[i];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `LSC_ASSERT_NOW(a_idle_div_free, state_reg == S_IDLE, !div_busy, "divider busy while idle")
    `LSC_ASSERT_NOW(a_done_in_div, div_done, state_reg == S_DIV, "divider done outside divide")
    `LSC_ASSERT_NEXT(a_xfer_merge, in_xfer, state_reg == S_MERGE, "transfer did not start merge")
    `LSC_ASSERT_NEXT(a_held_nonzero, held_reg != '0, held_reg != '0, "held error overwritten by zero")

endmodule

`default_nettype wire

[rtl/lsc_lane.sv]
`timescale 1ns / 1ps
`default_nettype none

module lsc_lane
    import lsc_pkg::*;
(
    input  wire logic [SAMPLE_W-1:0]    sample,
    input  wire logic [SAMPLE_W-1:0]    threshold,
    input  wire logic signed [SUM_W-1:0] weight,
    output logic                        black,
    output logic signed [SUM_W-1:0]     contrib
);

    always_comb
    begin
        black   = (sample >= threshold);
        contrib = black ? weight : '0;
    end

endmodule

`default_nettype wire

[rtl/lsc_merge.sv]
`timescale 1ns / 1ps
`default_nettype none

module lsc_merge
    import lsc_pkg::*;
(
    input  wire logic [NSENS-1:0]        black,
    input  wire logic signed [SUM_W-1:0] contrib [NSENS],
    output merge_t                       merged
);

    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        cnt;
    logic [MAX_SENS-1:0]     mask;
    logic                    centre;
    logic                    outer_white;

    always_comb
    begin
        sum  = '0;
        cnt  = '0;
        mask = '0;
        for (int i = 0; i < NSENS; i++)
        begin
            sum     = sum + contrib[i];
            cnt     = cnt + CNT_W'(black[i]);
            mask[i] = black[i];
        end
        centre      = black[NSENS/2 - 1] | black[NSENS/2];
        outer_white = ~black[0] & ~black[1] & ~black[NSENS-1] & ~black[NSENS-2];

        merged.sum         = sum;
        merged.black_count = cnt;
        merged.mask        = mask;
        merged.all_black   = (cnt == CNT_W'(NSENS));
        merged.all_white   = (cnt == '0);
        merged.approach    = centre & outer_white;
    end

endmodule

`default_nettype wire

[rtl/lsc_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module lsc_div
    import lsc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [MAG_W-1:0] dividend,
    input  wire logic [CNT_W-1:0] divisor,
    output logic                  busy,
    output logic                  done,
    output logic [MAG_W-1:0]      quotient
);

    localparam int STEP_W = $clog2(MAG_W + 1);

    logic [MAG_W-1:0]  quo_reg,  quo_next;
    logic [CNT_W-1:0]  rem_reg,  rem_next;
    logic [CNT_W-1:0]  dvs_reg,  dvs_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W:0]    trial;
    logic              fits;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[MAG_W-1]};
        fits      = (trial >= {1'b0, dvs_reg});
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            step_next = STEP_W'(MAG_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // restoring step, one quotient bit per cycle
            quo_next = {quo_reg[MAG_W-2:0], fits};
            rem_next = fits ? CNT_W'(trial - {1'b0, dvs_reg}) : CNT_W'(trial);
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        step_reg <= step_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire
